// ===== design/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg: shared types, codes and checksum helpers for the frame builder
// Holds the register file layout, the queue entry layout, register index and
// checksum kind codes, and the per-byte checksum update.
// ----------------------------------------------------------------------------
package cfb_pkg;

  // Length field arithmetic width (8..32) and edge byte limit (1..8)
  localparam int LENGTH_BITS    = 16;
  localparam int MAX_EDGE_BYTES = 8;

  localparam logic [31:0] LEN_MASK =
    (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LENGTH_BITS) - 64'd1);

  // Item queue between front and back; depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_INDEX_W = 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTES  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_COUNT  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_BYTES    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_COUNT    = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_BYTES  = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_OPTIONS = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECKSUM_KIND = 8'd7;

  // Checksum kinds
  localparam logic [2:0] CK_NONE  = 3'd0;
  localparam logic [2:0] CK_XOR   = 3'd1;
  localparam logic [2:0] CK_CRC8  = 3'd2;
  localparam logic [2:0] CK_CRC16 = 3'd3;
  localparam logic [2:0] CK_CRC32 = 3'd4;
  localparam logic [2:0] CK_SUM8  = 3'd5;
  localparam logic [2:0] CK_SUM16 = 3'd6;

  localparam logic [7:0]  CRC8_POLY  = 8'h07;
  localparam logic [15:0] CRC16_POLY = 16'hA001;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;
  localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] header_bytes;
    logic [3:0]  header_count;
    logic [63:0] tail_bytes;
    logic [3:0]  tail_count;
    logic [2:0]  length_bytes;
    logic [3:0]  field_options;
    logic [7:0]  function_code;
    logic [2:0]  checksum_kind;
  } cfg_t;

  // One classified input request
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] plen;
    logic        start;     // first request of a frame
    logic        fin;       // frame closes with this request
    logic        has_data;  // request carries a payload byte
  } entry_t;

  function automatic logic [3:0] edge_count(logic [3:0] c);
    logic [3:0] r;
    r = (c > 4'(MAX_EDGE_BYTES)) ? 4'(MAX_EDGE_BYTES) : c;
    return r;
  endfunction

  function automatic logic [31:0] chk_init(logic [2:0] kind);
    logic [31:0] r;
    case (kind)
      CK_CRC16: r = {16'h0, CRC16_INIT};
      CK_CRC32: r = CRC32_INIT;
      default:  r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] chk_update(logic [2:0] kind, logic [31:0] acc,
                                             logic [7:0] b);
    logic [31:0] a;
    a = acc;
    case (kind)
      CK_XOR: a = {24'h0, a[7:0] ^ b};
      CK_CRC8: begin
        a = {24'h0, a[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
          a[7:0] = a[7] ? ({a[6:0], 1'b0} ^ CRC8_POLY) : {a[6:0], 1'b0};
        end
      end
      CK_CRC16: begin
        a = {16'h0, a[15:0] ^ {8'h0, b}};
        for (int i = 0; i < 8; i++) begin
          a[15:0] = a[0] ? ({1'b0, a[15:1]} ^ CRC16_POLY) : {1'b0, a[15:1]};
        end
      end
      CK_CRC32: begin
        a = a ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
          a = a[0] ? ({1'b0, a[31:1]} ^ CRC32_POLY) : {1'b0, a[31:1]};
        end
      end
      CK_SUM8:  a = {24'h0, a[7:0] + b};
      CK_SUM16: a = {16'h0, a[15:0] + {8'h0, b}};
      default:  a = acc;
    endcase
    return a;
  endfunction

endpackage

// ===== design/cfb_front.sv =====
// ----------------------------------------------------------------------------
// cfb_front: input acceptance and frame classification
// Tracks frame boundaries from payload lengths and tags each request as
// frame start, frame end and payload carrier before queuing it.
// ----------------------------------------------------------------------------
module cfb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // [7:0] data_byte, [23:8] payload_length
  input  logic            q_full,
  output logic            q_push,
  output cfb_pkg::entry_t q_entry
);
  import cfb_pkg::*;

  logic        open;
  logic [15:0] rem;
  logic [15:0] plen;

  assign plen          = s_axis_tdata[23:8];
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_entry.data  = s_axis_tdata[7:0];
    q_entry.plen  = plen;
    q_entry.start = !open;
    if (open) begin
      q_entry.has_data = 1'b1;
      q_entry.fin      = (rem == 16'd1);
    end else begin
      q_entry.has_data = (plen != 16'd0);
      q_entry.fin      = (plen <= 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      rem  <= 16'd0;
    end else if (q_push) begin
      if (open) begin
        rem <= rem - 16'd1;
        if (rem == 16'd1) open <= 1'b0;
      end else if (plen > 16'd1) begin
        open <= 1'b1;
        rem  <= plen - 16'd1;
      end
    end
  end

endmodule

// ===== design/cfb_queue.sv =====
// ----------------------------------------------------------------------------
// cfb_queue: short request queue between front and back
// Register FIFO; the head entry stays visible until the back pops it.
// ----------------------------------------------------------------------------
module cfb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cfb_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cfb_pkg::entry_t head
);
  import cfb_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

// ===== design/cfb_back.sv =====
// ----------------------------------------------------------------------------
// cfb_back: frame sequencer, checksum and output register
// Walks header, length, sequence, code, payload, checksum and tail phases
// for the head request, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module cfb_back (
  input  logic            clk,
  input  logic            rst,
  input  cfb_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  cfb_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // frame_end
  output logic            m_axis_tuser    // [0] last
);
  import cfb_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_SEQ, PH_FC, PH_DATA, PH_CHK, PH_TAIL, PH_DONE
  } phase_t;

  function automatic phase_t next_from(logic [6:0] en, logic [2:0] p);
    phase_t r;
    r = PH_DONE;
    for (int i = 6; i >= 0; i--) begin
      if (en[i] && (3'(i) >= p)) r = phase_t'(3'(i));
    end
    return r;
  endfunction

  logic        started;
  phase_t      phase_r;
  logic [2:0]  idx_r;
  logic [31:0] acc;
  logic [15:0] seq;

  logic [3:0]  hc, tc, n;
  logic [2:0]  lb, chkn;
  logic [1:0]  sq, lsel, csel;
  logic        fcn, out_free, can_emit, skip, last_in_phase, item_last, checked;
  logic [6:0]  en;
  phase_t      first_phase, cur_phase, np;
  logic [2:0]  cur_idx;
  logic [31:0] len_sum, len_word, acc_base, crc_out;
  logic [7:0]  byte_out;

  always_comb begin
    hc   = edge_count(cfg.header_count);
    tc   = edge_count(cfg.tail_count);
    lb   = (cfg.length_bytes <= 3'd4) ? cfg.length_bytes : 3'd0;
    sq   = (cfg.field_options[2:1] == 2'd3) ? 2'd0 : cfg.field_options[2:1];
    fcn  = cfg.field_options[3];
    case (cfg.checksum_kind)
      CK_XOR, CK_CRC8, CK_SUM8: chkn = 3'd1;
      CK_CRC16, CK_SUM16:       chkn = 3'd2;
      CK_CRC32:                 chkn = 3'd4;
      default:                  chkn = 3'd0;
    endcase

    en[PH_HDR]  = q_head.start && (hc != 4'd0);
    en[PH_LEN]  = q_head.start && (lb != 3'd0);
    en[PH_SEQ]  = q_head.start && (sq != 2'd0);
    en[PH_FC]   = q_head.start && fcn;
    en[PH_DATA] = q_head.has_data;
    en[PH_CHK]  = q_head.fin && (chkn != 3'd0);
    en[PH_TAIL] = q_head.fin && (tc != 4'd0);

    first_phase = next_from(en, 3'd0);
    cur_phase   = started ? phase_r : first_phase;
    cur_idx     = started ? idx_r : 3'd0;

    case (cur_phase)
      PH_HDR:  n = hc;
      PH_LEN:  n = {1'b0, lb};
      PH_SEQ:  n = {2'b0, sq};
      PH_FC:   n = 4'd1;
      PH_DATA: n = 4'd1;
      PH_CHK:  n = {1'b0, chkn};
      PH_TAIL: n = tc;
      default: n = 4'd0;
    endcase

    out_free      = !m_axis_tvalid || m_axis_tready;
    can_emit      = q_valid && (cur_phase != PH_DONE) && out_free;
    skip          = q_valid && !started && (first_phase == PH_DONE);
    last_in_phase = ({1'b0, cur_idx} == (n - 4'd1));
    np            = last_in_phase ? next_from(en, 3'(cur_phase) + 3'd1) : cur_phase;
    item_last     = last_in_phase && (np == PH_DONE);
    q_pop         = skip || (can_emit && item_last);

    // Length value, wrapped to LENGTH_BITS
    len_sum  = 32'(q_head.plen) + 32'(sq) + 32'(fcn)
             + (cfg.field_options[0] ? (32'(hc) + 32'(lb)) : 32'd0);
    len_word = len_sum & LEN_MASK;
    lsel     = lb[1:0] - 2'd1 - cur_idx[1:0];

    // Restart the accumulator on the first byte of a frame
    acc_base = (!started && q_head.start) ? chk_init(cfg.checksum_kind) : acc;
    crc_out  = ~acc_base;
    csel     = 2'd3 - cur_idx[1:0];

    checked = 1'b0;
    case (cur_phase)
      PH_HDR:  byte_out = cfg.header_bytes[{cur_idx, 3'b000} +: 8];
      PH_LEN: begin
        checked  = 1'b1;
        byte_out = (lb == 3'd3) ? 8'h00 : len_word[{lsel, 3'b000} +: 8];
      end
      PH_SEQ: begin
        checked  = 1'b1;
        byte_out = (sq == 2'd2 && cur_idx == 3'd0) ? seq[15:8] : seq[7:0];
      end
      PH_FC: begin
        checked  = 1'b1;
        byte_out = cfg.function_code;
      end
      PH_DATA: begin
        checked  = 1'b1;
        byte_out = q_head.data;
      end
      PH_CHK: begin
        case (cfg.checksum_kind)
          CK_CRC32:           byte_out = crc_out[{csel, 3'b000} +: 8];
          CK_CRC16, CK_SUM16: byte_out = (cur_idx == 3'd0) ? acc_base[15:8]
                                                           : acc_base[7:0];
          default:            byte_out = acc_base[7:0];
        endcase
      end
      PH_TAIL: byte_out = cfg.tail_bytes[{cur_idx, 3'b000} +: 8];
      default: byte_out = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      phase_r       <= PH_HDR;
      idx_r         <= 3'd0;
      acc           <= 32'h0;
      seq           <= 16'h0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (can_emit) begin
        acc <= checked ? chk_update(cfg.checksum_kind, acc_base, byte_out) : acc_base;
        if (cur_phase == PH_SEQ && last_in_phase) seq <= seq + 16'd1;
        if (item_last) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          phase_r <= np;
          idx_r   <= last_in_phase ? 3'd0 : cur_idx + 3'd1;
        end
      end
      if (out_free) m_axis_tvalid <= can_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      m_axis_tdata <= byte_out;
      m_axis_tlast <= item_last && q_head.fin;
      m_axis_tuser <= item_last;
    end
  end

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("frame end not on the last byte of a request");
  a_started_has_head: assert property (@(posedge clk) disable iff (rst)
    started |-> q_valid)
    else $error("sequencer running without a queued request");
  a_emit_updates_out: assert property (@(posedge clk) disable iff (rst)
    can_emit |=> m_axis_tvalid)
    else $error("emitted byte not presented");
`endif

endmodule

// ===== design/configurable_frame_builder.sv =====
// ----------------------------------------------------------------------------
// configurable_frame_builder: serial frame builder with selectable checksum
// Wraps payload bytes in header, length, sequence, function code, checksum
// and tail, per a small register file.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake                      Payload
//  s_axis    in    s_axis_tvalid/s_axis_tready    data_byte, payload_length
//  m_axis    out   m_axis_tvalid/m_axis_tready    out_byte, frame_end, last
//  cfg       in    cfg_valid/cfg_ready            cfg_index, cfg_data
//
//  Output: one byte per cycle while the receiver accepts and requests wait.
//  A frame's first request gives header, length, sequence, code and payload
//  bytes, later requests their payload byte, the closing one adds checksum
//  and tail bytes. A request that yields no bytes is popped without output.
//  The sequencer's one-byte-per-cycle output register sets this rate.
//  Stalls: a four-entry request queue lets input run ahead of output.
//  Reset clears frame tracking, sequence counter, checksum and registers.
//
module configurable_frame_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // [7:0] data_byte,
                                                         // [23:8] payload_length
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] out_byte
  output logic                            m_axis_tlast,  // frame_end
  output logic                            m_axis_tuser,  // [0] last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import cfb_pkg::*;

  cfg_t   cfg;
  entry_t q_entry, q_head;
  logic   q_push, q_full, q_pop, q_valid;

  // Register writes are always taken; unknown indexes drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_BYTES:  cfg.header_bytes  <= cfg_data;
        REG_HEADER_COUNT:  cfg.header_count  <= cfg_data[3:0];
        REG_TAIL_BYTES:    cfg.tail_bytes    <= cfg_data;
        REG_TAIL_COUNT:    cfg.tail_count    <= cfg_data[3:0];
        REG_LENGTH_BYTES:  cfg.length_bytes  <= cfg_data[2:0];
        REG_FIELD_OPTIONS: cfg.field_options <= cfg_data[3:0];
        REG_FUNCTION_CODE: cfg.function_code <= cfg_data[7:0];
        REG_CHECKSUM_KIND: cfg.checksum_kind <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Front end: accept requests and tag frame start and end
  cfb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // Hold tagged requests until the sequencer is free
  cfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back end: emit frame bytes and advance the checksum
  cfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== verif/frame_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stream_checker: predicts and compares the framed byte stream
// Tracks register writes and accepted payload requests, builds the bytes
// each request should cause, and compares every output beat in order.
// ----------------------------------------------------------------------------
module frame_stream_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [7:0]                      m_axis_tdata,
  input  logic                            m_axis_tlast,
  input  logic                            m_axis_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  output int                              mismatch_total,
  output int                              beats_owed
);
  import cfb_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last_of_req;
  } beat_t;

  cfg_t        regs;
  logic [15:0] seq_num;
  logic [31:0] check_acc;
  logic [15:0] left_to_go;
  logic        in_frame;
  int          errs;

  logic [7:0]  req_bytes[$];   // bytes caused by the request being predicted
  int          end_at;         // index of the frame's closing byte, -1 if none
  beat_t       owed_beats[$];

  initial begin
    errs = 0;
  end

  function automatic logic [31:0] fold_byte(logic [2:0] kind, logic [31:0] acc,
                                            logic [7:0] b);
    logic [31:0] a;
    a = acc;
    case (kind)
      CK_XOR:  a = {24'd0, acc[7:0] ^ b};
      CK_CRC8: begin
        a = {24'd0, acc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
          a = a[7] ? (((a << 1) ^ {24'd0, CRC8_POLY}) & 32'hFF) : ((a << 1) & 32'hFF);
        end
      end
      CK_CRC16: begin
        a = {16'd0, acc[15:0] ^ {8'd0, b}};
        for (int k = 0; k < 8; k++) begin
          a = a[0] ? ((a >> 1) ^ {16'd0, CRC16_POLY}) : (a >> 1);
        end
      end
      CK_CRC32: begin
        a = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
          a = a[0] ? ((a >> 1) ^ CRC32_POLY) : (a >> 1);
        end
      end
      CK_SUM8:  a = (acc + {24'd0, b}) & 32'hFF;
      CK_SUM16: a = (acc + {24'd0, b}) & 32'hFFFF;
      default:  a = acc;
    endcase
    return a;
  endfunction

  task automatic put_plain(input logic [7:0] b);
    req_bytes.push_back(b);
  endtask

  task automatic put_summed(input logic [7:0] b);
    check_acc = fold_byte(regs.checksum_kind, check_acc, b);
    req_bytes.push_back(b);
  endtask

  task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    case (idx)
      REG_HEADER_BYTES:  regs.header_bytes  = val;
      REG_HEADER_COUNT:  regs.header_count  = val[3:0];
      REG_TAIL_BYTES:    regs.tail_bytes    = val;
      REG_TAIL_COUNT:    regs.tail_count    = val[3:0];
      REG_LENGTH_BYTES:  regs.length_bytes  = val[2:0];
      REG_FIELD_OPTIONS: regs.field_options = val[3:0];
      REG_FUNCTION_CODE: regs.function_code = val[7:0];
      REG_CHECKSUM_KIND: regs.checksum_kind = val[2:0];
      default: ;
    endcase
  endtask

  task automatic open_frame(input logic [15:0] plen);
    int          hc;
    int          lsz;
    int          sq;
    logic        fcode_on;
    logic [31:0] len;
    hc       = (regs.header_count > MAX_EDGE_BYTES) ? MAX_EDGE_BYTES : int'(regs.header_count);
    lsz      = (regs.length_bytes <= 3'd4) ? int'(regs.length_bytes) : 0;
    sq       = (regs.field_options[2:1] == 2'd3) ? 0 : int'(regs.field_options[2:1]);
    fcode_on = regs.field_options[3];
    case (regs.checksum_kind)
      CK_CRC16: check_acc = {16'd0, CRC16_INIT};
      CK_CRC32: check_acc = CRC32_INIT;
      default:  check_acc = 32'd0;
    endcase
    for (int i = 0; i < hc; i++) put_plain(regs.header_bytes[8*i +: 8]);
    len = 32'(sq) + 32'(fcode_on) + 32'(plen);
    if (regs.field_options[0]) len = len + 32'(hc) + 32'(lsz);
    len = len & LEN_MASK;
    if (lsz == 3) begin
      repeat (3) put_summed(8'h00);
    end else begin
      for (int i = lsz; i > 0; i--) put_summed(len[8*(i-1) +: 8]);
    end
    if (sq == 2) put_summed(seq_num[15:8]);
    if (sq != 0) begin
      put_summed(seq_num[7:0]);
      seq_num = seq_num + 16'd1;
    end
    if (fcode_on) put_summed(regs.function_code);
  endtask

  task automatic close_frame();
    logic [31:0] c;
    int          tc;
    c  = check_acc;
    tc = (regs.tail_count > MAX_EDGE_BYTES) ? MAX_EDGE_BYTES : int'(regs.tail_count);
    case (regs.checksum_kind)
      CK_XOR, CK_CRC8, CK_SUM8: put_plain(c[7:0]);
      CK_CRC16, CK_SUM16: begin
        put_plain(c[15:8]);
        put_plain(c[7:0]);
      end
      CK_CRC32: begin
        c = ~c;
        for (int i = 3; i >= 0; i--) put_plain(c[8*i +: 8]);
      end
      default: ;
    endcase
    for (int i = 0; i < tc; i++) put_plain(regs.tail_bytes[8*i +: 8]);
    if (req_bytes.size() > 0) end_at = req_bytes.size() - 1;
    in_frame   = 1'b0;
    left_to_go = 16'd0;
  endtask

  task automatic predict_request(input logic [7:0] data, input logic [15:0] plen);
    beat_t b;
    req_bytes.delete();
    end_at = -1;
    if (!in_frame) begin
      open_frame(plen);
      if (plen == 16'd0) begin
        close_frame();
      end else begin
        in_frame   = 1'b1;
        left_to_go = plen;
      end
    end
    if (in_frame) begin
      put_summed(data);
      left_to_go = left_to_go - 16'd1;
      if (left_to_go == 16'd0) close_frame();
    end
    for (int i = 0; i < req_bytes.size(); i++) begin
      b.out_byte    = req_bytes[i];
      b.frame_end   = (i == end_at);
      b.last_of_req = (i == req_bytes.size() - 1);
      owed_beats.push_back(b);
    end
  endtask

  task automatic check_beat();
    beat_t want;
    if (owed_beats.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t checker: unexpected beat %02h end %0b last %0b", $realtime,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end else begin
      want = owed_beats.pop_front();
      if (want.out_byte !== m_axis_tdata || want.frame_end !== m_axis_tlast ||
          want.last_of_req !== m_axis_tuser) begin
        errs++;
        if (errs <= 10)
          $display("%0t checker: expected %02h end %0b last %0b, got %02h end %0b last %0b",
                   $realtime, want.out_byte, want.frame_end, want.last_of_req,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs       = '0;
      seq_num    = 16'd0;
      check_acc  = 32'd0;
      left_to_go = 16'd0;
      in_frame   = 1'b0;
      owed_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata[7:0], s_axis_tdata[23:8]);
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
    beats_owed     <= owed_beats.size();
    mismatch_total <= errs;
  end

endmodule

// ===== verif/configurable_frame_builder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_frame_builder_tb: stimulus and verdict for the frame builder
// Drives register setups and payload requests with random gaps on both
// channels; the checker beside the block predicts every framed byte.
// ----------------------------------------------------------------------------
module configurable_frame_builder_tb;
  import cfb_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int IDLE_PCT     = 15;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 160;

  // Register indexes past the end of the register file
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_END  = 8'd8;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX = 8'hFF;

  // field_options bits
  localparam logic [3:0] OPT_LEN_HDR = 4'b0001;
  localparam logic [3:0] OPT_SEQ1    = 4'b0010;
  localparam logic [3:0] OPT_SEQ2    = 4'b0100;
  localparam logic [3:0] OPT_SEQ_BAD = 4'b0110;
  localparam logic [3:0] OPT_FCODE   = 4'b1000;

  localparam logic [2:0] CK_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;

  int mismatches;
  int owed;
  int items_sent = 0;
  bit calm = 1'b0;      // no idling on either side while set
  int hold_asks = 0;    // bump to make the receiver hold off
  int hold_seen = 0;
  int hold_left = 0;

  configurable_frame_builder u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frame_stream_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_total(mismatches),
    .beats_owed    (owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random back-pressure, a long hold-off on request, none when calm
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen     <= hold_asks;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Timeout: a hung block never drains its expectations
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("configurable_frame_builder_tb: done, errors");
    $finish;
  end

  // Offer one payload request; hold it until the block takes it. Valid stays
  // high on return so back-to-back requests need no extra edge.
  task automatic offer(input logic [7:0] data, input logic [15:0] plen);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {plen, data};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // One well-formed frame: plen on the first request, random filler after
  task automatic send_frame(input logic [15:0] plen);
    offer(8'($urandom), plen);
    for (int i = 1; i < plen; i++) offer(8'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(input logic [63:0] hdr, input logic [3:0] hcnt,
                            input logic [63:0] tl, input logic [3:0] tcnt,
                            input logic [2:0] lsz, input logic [3:0] opts,
                            input logic [7:0] fcode, input logic [2:0] kind);
    write_reg(REG_HEADER_BYTES, hdr);
    write_reg(REG_HEADER_COUNT, 64'(hcnt));
    write_reg(REG_TAIL_BYTES, tl);
    write_reg(REG_TAIL_COUNT, 64'(tcnt));
    write_reg(REG_LENGTH_BYTES, 64'(lsz));
    write_reg(REG_FIELD_OPTIONS, 64'(opts));
    write_reg(REG_FUNCTION_CODE, 64'(fcode));
    write_reg(REG_CHECKSUM_KIND, 64'(kind));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed beat, then cover requests that are
  // still queued but produce nothing
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_plen();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 6));
    return 16'($urandom_range(7, 24));
  endfunction

  initial begin
    int phase;
    int phase_start;
    phase = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Reset setup: everything off. An empty frame emits nothing at all,
    // then bare payload frames pass through with only frame_end marked.
    offer(8'h00, 16'd0);
    offer(8'hFF, 16'd1);
    offer(8'h00, 16'd2);
    offer(8'hFF, 16'hFFFF);
    settle();

    // Everything at its widest: saturated edge counts, 4-byte length counting
    // the header, 2-byte sequence, code byte and CRC-32. Empty frame gives
    // the longest burst.
    load_setup(64'h8877_6655_4433_2211, 4'd15, 64'hF0E1_D2C3_B4A5_9687, 4'd15,
               3'd4, OPT_LEN_HDR | OPT_SEQ2 | OPT_FCODE, 8'hFF, CK_CRC32);
    offer(8'h5A, 16'd0);
    offer(8'h00, 16'd3);
    offer(8'hFF, 16'd0);
    offer(8'h80, 16'd0);
    settle();

    // Writes past the register file are dropped; then a 3-byte length gives zeros,
    // and sequence size three and checksum kind seven both mean "off"
    write_reg(REG_PAST_END, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_TOP_INDEX, 64'hA5A5_A5A5_A5A5_A5A5);
    load_setup(64'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 3'd3,
               OPT_LEN_HDR | OPT_SEQ_BAD, 8'h00, CK_UNUSED);
    offer(8'h11, 16'd1);
    offer(8'h22, 16'd0);
    settle();

    // Full header, 1-byte length counting it, 1-byte sequence, CRC-16
    load_setup(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'd0, 4'd0, 3'd1,
               OPT_LEN_HDR | OPT_SEQ1, 8'h3C, CK_CRC16);
    offer(8'hFF, 16'd2);
    offer(8'h00, 16'd0);
    offer(8'h00, 16'd0);
    settle();

    // Remaining checksum kinds over a short two-byte frame
    load_setup(64'h0000_0000_0000_00C3, 4'd1, 64'h0000_0000_0000_0D0A, 4'd9, 3'd2,
               OPT_SEQ2 | OPT_FCODE, 8'h01, CK_XOR);
    send_frame(16'd2);
    settle();
    load_setup(64'h0000_0000_0000_00C3, 4'd1, 64'h0000_0000_0000_0D0A, 4'd2, 3'd2,
               OPT_SEQ2 | OPT_FCODE, 8'h80, CK_CRC8);
    send_frame(16'd2);
    settle();
    load_setup(64'h0000_0000_0000_00C3, 4'd1, 64'h0000_0000_0000_0D0A, 4'd2, 3'd2,
               OPT_SEQ2 | OPT_FCODE, 8'h7F, CK_SUM8);
    send_frame(16'd2);
    settle();
    load_setup(64'h0000_0000_0000_00C3, 4'd1, 64'h0000_0000_0000_0D0A, 4'd2, 3'd2,
               OPT_SEQ2 | OPT_FCODE, 8'hFE, CK_SUM16);
    send_frame(16'd2);
    settle();

    // Random setups, each followed by a burst of well-formed frames
    while (items_sent < RANDOM_ITEMS) begin
      load_setup({$urandom, $urandom}, 4'($urandom_range(15)),
                 {$urandom, $urandom}, 4'($urandom_range(15)),
                 3'($urandom_range(7)), 4'($urandom_range(15)),
                 8'($urandom_range(255)), 3'($urandom_range(7)));
      phase_start = items_sent;
      calm <= (phase == 1);
      if (phase == 2) hold_asks <= hold_asks + 1;  // receiver stalls, sender pushes on
      while (items_sent - phase_start < 20) begin
        send_frame(pick_plen());
        if (phase == 3 && items_sent - phase_start >= 10 && items_sent - phase_start < 14)
          settle();  // pause the sender until the output has caught up
      end
      settle();
      calm <= 1'b0;
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("configurable_frame_builder_tb: done, clean");
    end else begin
      $display("configurable_frame_builder_tb: done, errors");
    end
    $finish;
  end

endmodule
